// ----- design/deq_pkg.sv -----
// Shared types and constants for the deque-with-search core.
// No dependencies; used by deq_seq, the top level and the bench.
package deq_pkg;

    localparam int DEPTH_DEF       = 16;
    localparam int VALUE_WIDTH_DEF = 32;

    // fixed port field widths
    localparam int OP_W        = 3;
    localparam int DATA_W      = 32;
    localparam int COUNT_W     = 5;
    localparam int OUT_TDATA_W = 80;

    typedef enum logic [2:0] {
        OP_ADD_FRONT    = 3'd0,
        OP_ADD_BACK     = 3'd1,
        OP_REMOVE_FRONT = 3'd2,
        OP_REMOVE_BACK  = 3'd3,
        OP_CONTAINS     = 3'd4,
        OP_REMOVE_VALUE = 3'd5
    } op_t;

    typedef enum logic [1:0] {
        STAT_OK        = 2'd0,
        STAT_FULL      = 2'd1,
        STAT_EMPTY     = 2'd2,
        STAT_NOT_FOUND = 2'd3
    } status_t;

    typedef enum logic [3:0] {
        SEQ_IDLE,
        SEQ_DECODE,
        SEQ_WRITE,
        SEQ_HEAD,
        SEQ_SEARCH,
        SEQ_SHIFT,
        SEQ_REFRESH0,
        SEQ_REFRESH1,
        SEQ_REFRESH2,
        SEQ_FINISH
    } seq_state_t;

    typedef struct packed {
        status_t             status;
        logic                found;
        logic [DATA_W-1:0]   front_value;
        logic [DATA_W-1:0]   back_value;
        logic [COUNT_W-1:0]  entry_count;
        logic                is_empty;
    } result_t;

endpackage

// ----- design/deq_store.sv -----
// Entry store: one write port, one read port with registered read data.
// Depends on nothing but its parameters.
module deq_store #(
    parameter int DEPTH       = 16,
    parameter int VALUE_WIDTH = 32
) (
    input  logic                           aclk,
    input  logic                           wr_en,
    input  logic [$clog2(DEPTH)-1:0]       wr_addr,
    input  logic [VALUE_WIDTH-1:0]         wr_data,
    input  logic                           rd_en,
    input  logic [$clog2(DEPTH)-1:0]       rd_addr,
    output logic [VALUE_WIDTH-1:0]         rd_data
);

    logic [VALUE_WIDTH-1:0] mem_array [DEPTH];
    logic [VALUE_WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_array[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem_array[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- design/deq_seq.sv -----
// Sequencer for the deque: one slot adder shared by the steps and one equality
// compare for the search. Depends on deq_pkg; drives the deq_store ports.
module deq_seq #(
    parameter int DEPTH       = deq_pkg::DEPTH_DEF,
    parameter int VALUE_WIDTH = deq_pkg::VALUE_WIDTH_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    // command side
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [deq_pkg::OP_W-1:0]      in_op,
    input  logic [deq_pkg::DATA_W-1:0]    in_value,
    // result side
    output logic                          res_valid,
    input  logic                          res_ready,
    output deq_pkg::result_t              res,
    // store ports
    output logic                          mem_we,
    output logic [$clog2(DEPTH)-1:0]      mem_waddr,
    output logic [VALUE_WIDTH-1:0]        mem_wdata,
    output logic                          mem_re,
    output logic [$clog2(DEPTH)-1:0]      mem_raddr,
    input  logic [VALUE_WIDTH-1:0]        mem_rdata
);

    localparam int IW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    deq_pkg::seq_state_t state_reg, state_next;

    logic [deq_pkg::OP_W-1:0] op_reg, op_next;
    logic [VALUE_WIDTH-1:0]   key_reg, key_next;
    logic [IW-1:0]            head_reg, head_next;
    logic [CW-1:0]            count_reg, count_next;
    logic [CW-1:0]            off_reg, off_next;
    deq_pkg::status_t         status_reg, status_next;
    logic                     found_reg, found_next;
    logic [VALUE_WIDTH-1:0]   front_reg, front_next;
    logic [VALUE_WIDTH-1:0]   back_reg, back_next;
    logic                     rd_vld_reg, rd_vld_next;
    logic [CW-1:0]            rd_off_reg, rd_off_next;
    logic [IW-1:0]            rd_slot_reg, rd_slot_next;
    logic [IW-1:0]            wr_slot_reg, wr_slot_next;

    // shared slot adder: (head + offset) mod DEPTH, offset < DEPTH
    logic [IW:0]   slot_sum;
    logic [IW-1:0] slot;
    logic          match;
    logic          more;
    logic          accept;

    assign slot_sum = {1'b0, head_reg} + (IW+1)'(off_reg);
    assign slot     = (slot_sum >= (IW+1)'(DEPTH)) ? IW'(slot_sum - (IW+1)'(DEPTH))
                                                   : IW'(slot_sum);
    assign match    = rd_vld_reg && (mem_rdata == key_reg);
    assign more     = off_reg < count_reg;
    assign accept   = in_valid && (state_reg == deq_pkg::SEQ_IDLE);

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            deq_pkg::SEQ_IDLE: begin
                if (in_valid) state_next = deq_pkg::SEQ_DECODE;
            end
            deq_pkg::SEQ_DECODE: begin
                state_next = deq_pkg::SEQ_FINISH;
                case (op_reg) inside
                    deq_pkg::OP_ADD_FRONT, deq_pkg::OP_ADD_BACK: begin
                        if (count_reg != CW'(DEPTH)) state_next = deq_pkg::SEQ_WRITE;
                    end
                    deq_pkg::OP_REMOVE_FRONT: begin
                        if (count_reg != '0) state_next = deq_pkg::SEQ_HEAD;
                    end
                    deq_pkg::OP_REMOVE_BACK: begin
                        if (count_reg != '0) state_next = deq_pkg::SEQ_REFRESH0;
                    end
                    deq_pkg::OP_CONTAINS, deq_pkg::OP_REMOVE_VALUE: begin
                        if (count_reg != '0) state_next = deq_pkg::SEQ_SEARCH;
                    end
                    default: state_next = deq_pkg::SEQ_FINISH;
                endcase
            end
            deq_pkg::SEQ_WRITE:    state_next = deq_pkg::SEQ_REFRESH0;
            deq_pkg::SEQ_HEAD:     state_next = deq_pkg::SEQ_REFRESH0;
            deq_pkg::SEQ_SEARCH: begin
                if (match) begin
                    state_next = (op_reg == deq_pkg::OP_REMOVE_VALUE) ? deq_pkg::SEQ_SHIFT
                                                                      : deq_pkg::SEQ_FINISH;
                end else if (!more && !rd_vld_reg) begin
                    state_next = deq_pkg::SEQ_FINISH;
                end
            end
            deq_pkg::SEQ_SHIFT: begin
                if (!more && !rd_vld_reg) state_next = deq_pkg::SEQ_REFRESH0;
            end
            deq_pkg::SEQ_REFRESH0: begin
                state_next = (count_reg == '0) ? deq_pkg::SEQ_FINISH : deq_pkg::SEQ_REFRESH1;
            end
            deq_pkg::SEQ_REFRESH1: state_next = deq_pkg::SEQ_REFRESH2;
            deq_pkg::SEQ_REFRESH2: state_next = deq_pkg::SEQ_FINISH;
            deq_pkg::SEQ_FINISH: begin
                if (res_ready) state_next = deq_pkg::SEQ_IDLE;
            end
            default: state_next = deq_pkg::SEQ_IDLE;
        endcase
    end

    // datapath and store controls
    always_comb begin
        op_next      = op_reg;
        key_next     = key_reg;
        head_next    = head_reg;
        count_next   = count_reg;
        off_next     = off_reg;
        status_next  = status_reg;
        found_next   = found_reg;
        front_next   = front_reg;
        back_next    = back_reg;
        rd_vld_next  = 1'b0;
        rd_off_next  = rd_off_reg;
        rd_slot_next = rd_slot_reg;
        wr_slot_next = wr_slot_reg;
        mem_we       = 1'b0;
        mem_waddr    = slot;
        mem_wdata    = key_reg;
        mem_re       = 1'b0;
        mem_raddr    = slot;

        case (state_reg)
            deq_pkg::SEQ_IDLE: begin
                if (accept) begin
                    op_next     = in_op;
                    key_next    = VALUE_WIDTH'(in_value);
                    status_next = deq_pkg::STAT_OK;
                    found_next  = 1'b0;
                end
            end
            deq_pkg::SEQ_DECODE: begin
                case (op_reg) inside
                    deq_pkg::OP_ADD_FRONT, deq_pkg::OP_ADD_BACK: begin
                        if (count_reg == CW'(DEPTH)) begin
                            status_next = deq_pkg::STAT_FULL;
                        end else begin
                            off_next = (op_reg == deq_pkg::OP_ADD_FRONT) ? CW'(DEPTH - 1)
                                                                         : count_reg;
                        end
                    end
                    deq_pkg::OP_REMOVE_FRONT, deq_pkg::OP_REMOVE_BACK: begin
                        if (count_reg == '0) begin
                            status_next = deq_pkg::STAT_EMPTY;
                        end else if (op_reg == deq_pkg::OP_REMOVE_FRONT) begin
                            off_next = CW'(1);
                        end else begin
                            count_next = count_reg - CW'(1);
                            off_next   = '0;
                        end
                    end
                    deq_pkg::OP_CONTAINS, deq_pkg::OP_REMOVE_VALUE: begin
                        if (count_reg == '0) status_next = deq_pkg::STAT_EMPTY;
                        else                 off_next    = '0;
                    end
                    default: ;
                endcase
            end
            deq_pkg::SEQ_WRITE: begin
                mem_we = 1'b1;
                if (op_reg == deq_pkg::OP_ADD_FRONT) head_next = slot;
                count_next = count_reg + CW'(1);
                off_next   = '0;
            end
            deq_pkg::SEQ_HEAD: begin
                head_next  = slot;
                count_next = count_reg - CW'(1);
                off_next   = '0;
            end
            deq_pkg::SEQ_SEARCH: begin
                // one read issued per cycle while entries remain and no match is seen, compared in the next cycle
                if (more && !match) begin
                    mem_re       = 1'b1;
                    rd_vld_next  = 1'b1;
                    rd_off_next  = off_reg;
                    rd_slot_next = slot;
                    off_next     = off_reg + CW'(1);
                end
                if (match) begin
                    found_next   = 1'b1;
                    off_next     = rd_off_reg + CW'(1);
                    wr_slot_next = rd_slot_reg;
                end else if (!more && !rd_vld_reg) begin
                    status_next = deq_pkg::STAT_NOT_FOUND;
                end
            end
            deq_pkg::SEQ_SHIFT: begin
                // read entry i+1 while entry i-1's successor is written back
                if (more) begin
                    mem_re       = 1'b1;
                    rd_vld_next  = 1'b1;
                    rd_off_next  = off_reg;
                    rd_slot_next = slot;
                    off_next     = off_reg + CW'(1);
                end
                if (rd_vld_reg) begin
                    mem_we       = 1'b1;
                    mem_waddr    = wr_slot_reg;
                    mem_wdata    = mem_rdata;
                    wr_slot_next = rd_slot_reg;
                end
                if (!more && !rd_vld_reg) begin
                    count_next = count_reg - CW'(1);
                    off_next   = '0;
                end
            end
            deq_pkg::SEQ_REFRESH0: begin
                if (count_reg != '0) begin
                    mem_re   = 1'b1;
                    off_next = count_reg - CW'(1);
                end
            end
            deq_pkg::SEQ_REFRESH1: begin
                front_next = mem_rdata;
                mem_re     = 1'b1;
            end
            deq_pkg::SEQ_REFRESH2: begin
                back_next = mem_rdata;
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= deq_pkg::SEQ_IDLE;
            head_reg   <= '0;
            count_reg  <= '0;
            rd_vld_reg <= 1'b0;
        end else begin
            state_reg  <= state_next;
            head_reg   <= head_next;
            count_reg  <= count_next;
            rd_vld_reg <= rd_vld_next;
        end
    end

    always_ff @(posedge aclk) begin
        op_reg      <= op_next;
        key_reg     <= key_next;
        off_reg     <= off_next;
        status_reg  <= status_next;
        found_reg   <= found_next;
        front_reg   <= front_next;
        back_reg    <= back_next;
        rd_off_reg  <= rd_off_next;
        rd_slot_reg <= rd_slot_next;
        wr_slot_reg <= wr_slot_next;
    end

    assign in_ready  = (state_reg == deq_pkg::SEQ_IDLE);
    assign res_valid = (state_reg == deq_pkg::SEQ_FINISH);

    always_comb begin
        res.status      = status_reg;
        res.found       = found_reg;
        res.front_value = (count_reg == '0) ? '0 : deq_pkg::DATA_W'(front_reg);
        res.back_value  = (count_reg == '0) ? '0 : deq_pkg::DATA_W'(back_reg);
        res.entry_count = deq_pkg::COUNT_W'(count_reg);
        res.is_empty    = (count_reg == '0);
    end

endmodule

// ----- design/deque_with_search_and_remove_core.sv -----
// Top level of the bounded deque with value search and middle removal.
// Depends on deq_pkg, deq_store and deq_seq.
//
//  channel | dir | ports                      | word
//  --------+-----+----------------------------+-------------------------------------------
//  s_      | in  | s_tvalid s_tready s_tdata  | op in tuser[2:0], value in tdata[31:0]
//          |     | s_tuser                    |
//  m_      | out | m_tvalid m_tready m_tdata  | status, found, front, back, count, empty
//
// Rejections and unused codes go from decode straight to the result. Successful adds
// and removals pass through the front and back refresh before answering, contains
// never does; search and gap closing walk the queue one entry a
// cycle through the store's one read port. Reset clears head, count and control
// state, not the store. A stalled m_ side holds its word in the output register
// while the next s_ word is already being worked on.
module deque_with_search_and_remove_core #(
    parameter int DEPTH       = deq_pkg::DEPTH_DEF,
    parameter int VALUE_WIDTH = deq_pkg::VALUE_WIDTH_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [deq_pkg::DATA_W-1:0]          s_tdata,  // [31:0] value
    input  logic [deq_pkg::OP_W-1:0]            s_tuser,  // [2:0] operation
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // [1:0] status, [2] found, [34:3] front_value, [66:35] back_value,
    // [71:67] entry_count, [72] is_empty, [79:73] zero
    output logic [deq_pkg::OUT_TDATA_W-1:0]     m_tdata
);

    localparam int IW = $clog2(DEPTH);
    localparam int RES_W = $bits(deq_pkg::result_t);

    logic                  mem_we;
    logic [IW-1:0]         mem_waddr;
    logic [VALUE_WIDTH-1:0] mem_wdata;
    logic                  mem_re;
    logic [IW-1:0]         mem_raddr;
    logic [VALUE_WIDTH-1:0] mem_rdata;

    logic                  res_valid;
    logic                  res_ready;
    deq_pkg::result_t      res;

    logic                  m_tvalid_reg, m_tvalid_next;
    logic [deq_pkg::OUT_TDATA_W-1:0] m_tdata_reg, m_tdata_next;

    deq_store #(
        .DEPTH       (DEPTH),
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_store (
        .aclk    (aclk),
        .wr_en   (mem_we),
        .wr_addr (mem_waddr),
        .wr_data (mem_wdata),
        .rd_en   (mem_re),
        .rd_addr (mem_raddr),
        .rd_data (mem_rdata)
    );

    deq_seq #(
        .DEPTH       (DEPTH),
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_seq (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_op     (s_tuser),
        .in_value  (s_tdata),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res),
        .mem_we    (mem_we),
        .mem_waddr (mem_waddr),
        .mem_wdata (mem_wdata),
        .mem_re    (mem_re),
        .mem_raddr (mem_raddr),
        .mem_rdata (mem_rdata)
    );

    // output register frees the sequencer as soon as the result is parked
    assign res_ready = !m_tvalid_reg || m_tready;

    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;
        if (m_tvalid_reg && m_tready) m_tvalid_next = 1'b0;
        if (res_valid && res_ready) begin
            m_tvalid_next = 1'b1;
            m_tdata_next  = '0;
            m_tdata_next[1:0]   = res.status;
            m_tdata_next[2]     = res.found;
            m_tdata_next[34:3]  = res.front_value;
            m_tdata_next[66:35] = res.back_value;
            m_tdata_next[71:67] = res.entry_count;
            m_tdata_next[72]    = res.is_empty;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else begin
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_tdata_reg <= m_tdata_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // result layout fits inside the padded word
    if (RES_W > deq_pkg::OUT_TDATA_W) begin : g_bad_width
        $error("result wider than m_tdata");
    end

endmodule

// ----- bench/testbench.sv -----
`timescale 1ns / 1ps
// Self-checking bench for deque_with_search_and_remove_core: directed and random
// request words, a queue-based shadow of the deque, field-by-field result checks.
// Depends on deq_pkg and the core RTL.
module testbench;

    localparam int DEPTH         = deq_pkg::DEPTH_DEF;
    localparam int REQUEST_TOTAL = 1300;
    localparam int CALM_FROM     = 1150;           // no idling from here on
    localparam int DRAIN_CYCLES  = 2 * DEPTH + 16; // slack after the last result, scaled with depth

    // op codes the core must ignore
    localparam logic [deq_pkg::OP_W-1:0] OP_SPARE_LO = 3'd6;
    localparam logic [deq_pkg::OP_W-1:0] OP_SPARE_HI = 3'd7;

    typedef enum int {MODE_FILL, MODE_DRAIN, MODE_SEARCH, MODE_MIXED} mix_t;

    // Shadow deque plus the queue of outcomes still owed by the core.
    class deque_shadow;
        logic [deq_pkg::DATA_W-1:0] held_values[$];
        deq_pkg::result_t           pending_outcomes[$];
        int                         mismatches;
        int                         checked;
        int                         requests;
        int                         deepest;
        int                         spare_seen;
        int                         status_seen[4];

        function new();
            mismatches = 0;
            checked    = 0;
            requests   = 0;
            deepest    = 0;
            spare_seen = 0;
            foreach (status_seen[i]) status_seen[i] = 0;
        endfunction

        // Apply one accepted request word and queue the outcome it must produce.
        function void apply_request(logic [deq_pkg::OP_W-1:0] op,
                                    logic [deq_pkg::DATA_W-1:0] value);
            deq_pkg::result_t outcome;
            int               hit;
            outcome.status = deq_pkg::STAT_OK;
            outcome.found  = 1'b0;
            hit            = -1;
            requests++;
            case (op)
                deq_pkg::OP_ADD_FRONT, deq_pkg::OP_ADD_BACK: begin
                    if (held_values.size() >= DEPTH)
                        outcome.status = deq_pkg::STAT_FULL;
                    else if (op == deq_pkg::OP_ADD_FRONT)
                        held_values.push_front(value);
                    else
                        held_values.push_back(value);
                end
                deq_pkg::OP_REMOVE_FRONT, deq_pkg::OP_REMOVE_BACK: begin
                    if (held_values.size() == 0)
                        outcome.status = deq_pkg::STAT_EMPTY;
                    else if (op == deq_pkg::OP_REMOVE_FRONT)
                        void'(held_values.pop_front());
                    else
                        void'(held_values.pop_back());
                end
                deq_pkg::OP_CONTAINS, deq_pkg::OP_REMOVE_VALUE: begin
                    if (held_values.size() == 0) begin
                        outcome.status = deq_pkg::STAT_EMPTY;
                    end else begin
                        // first match counted from the front
                        foreach (held_values[i])
                            if (hit < 0 && held_values[i] == value) hit = i;
                        if (hit < 0) begin
                            outcome.status = deq_pkg::STAT_NOT_FOUND;
                        end else begin
                            outcome.found = 1'b1;
                            if (op == deq_pkg::OP_REMOVE_VALUE) held_values.delete(hit);
                        end
                    end
                end
                default: spare_seen++;
            endcase
            outcome.entry_count = deq_pkg::COUNT_W'(held_values.size());
            outcome.is_empty    = (held_values.size() == 0);
            outcome.front_value = outcome.is_empty ? '0 : held_values[0];
            outcome.back_value  = outcome.is_empty ? '0 : held_values[$];
            status_seen[outcome.status]++;
            if (held_values.size() > deepest) deepest = held_values.size();
            pending_outcomes.push_back(outcome);
        endfunction

        function void compare_field(string name, logic [deq_pkg::DATA_W-1:0] want,
                                    logic [deq_pkg::DATA_W-1:0] got);
            if (want !== got) begin
                mismatches++;
                $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
            end
        endfunction

        // Check one result word against the oldest outstanding outcome.
        function void check_outcome(logic [deq_pkg::OUT_TDATA_W-1:0] word);
            deq_pkg::result_t want;
            if (pending_outcomes.size() == 0) begin
                mismatches++;
                $display("%0t: result word %h with no outcome pending", $time, word);
                return;
            end
            want = pending_outcomes.pop_front();
            checked++;
            compare_field("status", want.status, word[1:0]);
            compare_field("found", want.found, word[2]);
            compare_field("front_value", want.front_value, word[34:3]);
            compare_field("back_value", want.back_value, word[66:35]);
            compare_field("entry_count", want.entry_count, word[71:67]);
            compare_field("is_empty", want.is_empty, word[72]);
            compare_field("padding", '0, word[deq_pkg::OUT_TDATA_W-1:73]);
        endfunction
    endclass

    logic                            aclk     = 1'b0;
    logic                            aresetn  = 1'b0;
    logic                            s_tvalid = 1'b0;
    logic                            s_tready;
    logic [deq_pkg::DATA_W-1:0]      s_tdata  = '0;
    logic [deq_pkg::OP_W-1:0]        s_tuser  = '0;
    logic                            m_tvalid;
    logic                            m_tready = 1'b0;
    logic [deq_pkg::OUT_TDATA_W-1:0] m_tdata;

    logic        calm         = 1'b0;  // end of run: both sides stop idling
    logic        sender_idles = 1'b0;  // per-phase switch for s_ side gaps
    deque_shadow shadow;

    deque_with_search_and_remove_core uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),   // [31:0] value
        .s_tuser  (s_tuser),   // [2:0] operation
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)    // status, found, front, back, count, empty, pad
    );

    initial forever #1 aclk = ~aclk;

    // Send one request word; optional gap first, then hold until accepted.
    // Only one NBA to s_tvalid per edge: either the gap drop or the raise.
    task automatic send_word(input logic [deq_pkg::OP_W-1:0] op,
                             input logic [deq_pkg::DATA_W-1:0] value);
        if (!calm && sender_idles && $urandom_range(0, 3) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= value;
        do @(posedge aclk); while (!s_tready);
        shadow.apply_request(op, value);
    endtask

    // Values lean on corners, a small pool, and values already held,
    // so searches hit at all offsets and duplicates show up.
    function automatic logic [deq_pkg::DATA_W-1:0] pick_value();
        int n;
        n = shadow.held_values.size();
        case ($urandom_range(0, 5))
            0, 1: return $urandom();
            2: begin
                case ($urandom_range(0, 3))
                    0:       return 32'h8000_0000;
                    1:       return 32'h7fff_ffff;
                    2:       return 32'hffff_ffff;
                    default: return 32'h0000_0000;
                endcase
            end
            3: begin
                if (n != 0) return shadow.held_values[$urandom_range(0, n - 1)];
                return $urandom();
            end
            default: return $urandom_range(0, 11);
        endcase
    endfunction

    // Op mix per phase: fill pushes toward full, drain toward empty.
    function automatic logic [deq_pkg::OP_W-1:0] choose_op(mix_t mix);
        int roll;
        roll = $urandom_range(0, 99);
        case (mix)
            MODE_FILL: begin
                if (roll < 38) return deq_pkg::OP_ADD_FRONT;
                if (roll < 76) return deq_pkg::OP_ADD_BACK;
                if (roll < 84) return deq_pkg::OP_CONTAINS;
                if (roll < 90) return deq_pkg::OP_REMOVE_VALUE;
                if (roll < 95) return deq_pkg::OP_REMOVE_FRONT;
                return deq_pkg::OP_REMOVE_BACK;
            end
            MODE_DRAIN: begin
                if (roll < 25) return deq_pkg::OP_REMOVE_FRONT;
                if (roll < 50) return deq_pkg::OP_REMOVE_BACK;
                if (roll < 75) return deq_pkg::OP_REMOVE_VALUE;
                if (roll < 85) return deq_pkg::OP_CONTAINS;
                if (roll < 93) return deq_pkg::OP_ADD_BACK;
                return deq_pkg::OP_ADD_FRONT;
            end
            MODE_SEARCH: begin
                if (roll < 35) return deq_pkg::OP_CONTAINS;
                if (roll < 60) return deq_pkg::OP_REMOVE_VALUE;
                if (roll < 75) return deq_pkg::OP_ADD_BACK;
                if (roll < 90) return deq_pkg::OP_ADD_FRONT;
                if (roll < 95) return deq_pkg::OP_REMOVE_FRONT;
                return deq_pkg::OP_REMOVE_BACK;
            end
            default: return deq_pkg::OP_W'($urandom_range(0, 7));  // includes the unused codes
        endcase
    endfunction

    // m_ side: random stall bursts between ready stretches, none once calm.
    initial begin
        wait (aresetn === 1'b1);
        @(posedge aclk);
        forever begin
            if (!calm && $urandom_range(0, 4) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 13)) @(posedge aclk);
            end
            m_tready <= 1'b1;
            repeat ($urandom_range(1, 24)) @(posedge aclk);
        end
    end

    // Result monitor: sample pre-edge values of the m_ handshake.
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) shadow.check_outcome(m_tdata);
    end

    // Hard stop well past the slowest legal run.
    initial begin
        #2_000_000;
        $display("FAILED: results differ");
        $finish;
    end

    initial begin
        mix_t mix;
        int   sent;
        int   phase_left;
        shadow = new();
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        sender_idles = 1'b1;

        // Directed: empty rejections, unused codes, corner values,
        // hit / miss searches, middle and back removal of a duplicate.
        send_word(deq_pkg::OP_REMOVE_FRONT, 32'hdead_beef);
        send_word(deq_pkg::OP_REMOVE_BACK, 32'h0000_0000);
        send_word(deq_pkg::OP_CONTAINS, 32'h0000_0000);
        send_word(deq_pkg::OP_REMOVE_VALUE, 32'hffff_ffff);
        send_word(OP_SPARE_LO, 32'h1234_5678);
        send_word(deq_pkg::OP_ADD_BACK, 32'h7fff_ffff);
        send_word(deq_pkg::OP_ADD_FRONT, 32'h8000_0000);
        send_word(deq_pkg::OP_ADD_BACK, 32'hffff_ffff);
        send_word(deq_pkg::OP_ADD_FRONT, 32'h0000_0000);
        send_word(deq_pkg::OP_ADD_BACK, 32'h8000_0000);
        send_word(deq_pkg::OP_CONTAINS, 32'h8000_0000);
        send_word(deq_pkg::OP_CONTAINS, 32'h0001_2345);
        send_word(deq_pkg::OP_REMOVE_VALUE, 32'h0001_2345);
        send_word(deq_pkg::OP_REMOVE_VALUE, 32'h8000_0000);  // first copy, mid-queue
        send_word(deq_pkg::OP_REMOVE_VALUE, 32'h8000_0000);  // second copy, at the back
        send_word(OP_SPARE_HI, 32'hffff_ffff);
        send_word(deq_pkg::OP_REMOVE_FRONT, 32'hffff_ffff);
        send_word(deq_pkg::OP_REMOVE_BACK, 32'h5555_5555);
        send_word(deq_pkg::OP_CONTAINS, 32'h7fff_ffff);
        send_word(deq_pkg::OP_REMOVE_VALUE, 32'h7fff_ffff);  // last entry, back to empty
        send_word(deq_pkg::OP_REMOVE_VALUE, 32'h7fff_ffff);

        // Random phases; the first one fills so full rejection comes early.
        mix        = MODE_FILL;
        phase_left = 60;
        sent       = 0;
        while (sent < REQUEST_TOTAL) begin
            if (phase_left == 0) begin
                mix          = mix_t'($urandom_range(0, 3));
                phase_left   = $urandom_range(20, 60);
                sender_idles = ($urandom_range(0, 3) != 0);
            end
            calm = (sent >= CALM_FROM);
            send_word(choose_op(mix), pick_value());
            sent++;
            phase_left--;
        end
        s_tvalid <= 1'b0;

        while (shadow.pending_outcomes.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("Run covered %0d request words: %0d ok, %0d full, %0d empty, %0d not found.",
                 shadow.requests, shadow.status_seen[deq_pkg::STAT_OK],
                 shadow.status_seen[deq_pkg::STAT_FULL],
                 shadow.status_seen[deq_pkg::STAT_EMPTY],
                 shadow.status_seen[deq_pkg::STAT_NOT_FOUND]);
        $display("Unused op codes %0d times, deepest fill %0d of %0d, %0d result words checked.",
                 shadow.spare_seen, shadow.deepest, DEPTH, shadow.checked);
        if (shadow.mismatches == 0 && shadow.pending_outcomes.size() == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule

// ----- deque_with_search_and_remove_core.f -----
design/deq_pkg.sv
design/deq_store.sv
design/deq_seq.sv
design/deque_with_search_and_remove_core.sv
bench/testbench.sv
